[hdl/pkdt_pkg.sv]
// ----------------------------------------------------------------------------
// pkdt_pkg
// Types, codes and constants shared by the double-tap detector files.
// ----------------------------------------------------------------------------
package pkdt_pkg;

  localparam int unsigned CODE_W = 16;
  localparam int unsigned TIME_W = 16;
  localparam logic [TIME_W-1:0] TERM_RESET = 16'd200;

  // Input item kinds
  typedef enum logic [1:0] {
    MODE_KEY   = 2'd0,
    MODE_POLL  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  // Result actions
  typedef enum logic [1:0] {
    ACT_REG   = 2'd0,
    ACT_UNREG = 2'd1,
    ACT_DONE  = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_WAIT   = 2'd1,
    ST_SINGLE = 2'd2,
    ST_DOUBLE = 2'd3
  } stage_t;

  typedef struct packed {
    mode_t             mode;
    logic [2:0]        row;
    logic [2:0]        col;
    logic              down;
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] now;
    logic              base;
  } item_t;

  typedef struct packed {
    stage_t            stage;
    logic [2:0]        row;
    logic [2:0]        col;
    logic              held;
    logic [TIME_W-1:0] start;
    logic [CODE_W-1:0] single;
    logic [CODE_W-1:0] dbl;
  } dance_t;

  typedef struct packed {
    act_t              action;
    logic [CODE_W-1:0] code;
    logic              consumed;
    logic              last;
  } res_t;

  // Up to three results per input item, item[0] goes out first
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     item;
  } rlist_t;

  function automatic rlist_t push(rlist_t l, res_t x);
    rlist_t o;
    o = l;
    if (l.cnt != 2'd3) begin
      o.item[l.cnt] = x;
      o.cnt         = l.cnt + 2'd1;
    end
    return o;
  endfunction

  function automatic res_t key_res(act_t a, logic [CODE_W-1:0] c);
    res_t r;
    r.action   = a;
    r.code     = c;
    r.consumed = 1'b0;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

[hdl/per_key_double_tap_detector_unit.sv]
// ----------------------------------------------------------------------------
// per_key_double_tap_detector_unit
// Per-key double-tap detector with a writable table of double codes.
// ----------------------------------------------------------------------------
// Each accepted input item gives one to three result beats, the last marked
// by out_tlast. An accepted item is held in an input register, decided in one
// pass and loaded into a three-entry result buffer that drains one beat per
// cycle while out_tready is high; the item passes the input register and then
// the result buffer before its first beat is on the outputs. A new item is
// accepted in every cycle in which the input register is free or moves on; it
// moves on when the result buffer is empty or its last beat is taken, so a new
// item can be taken while the last beat of the previous one goes out. The
// double-code table is read when an item is accepted and written by table-write
// items at their acceptance; reset clears it at once through per-entry valid
// flops, so there is no clearing pass.
// ----------------------------------------------------------------------------
module per_key_double_tap_detector_unit #(
  parameter int ROWS = 6,
  parameter int COLS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // key_row[2:0], key_col[5:3], key_down[6],
                                  // code_in[22:7], now_ms[38:23], on_base_layer[39]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // code_out[15:0], consumed[16], zero[23:17]
  output logic [1:0]  out_tuser,  // action[1:0]
  output logic        out_tlast,  // last
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data // tapping_term_ms
);
  import pkdt_pkg::*;

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t             in_item;
  logic              in_edit;
  logic [AW-1:0]     in_addr;
  logic              in_beat;
  logic              tbl_wr;

  logic [TIME_W-1:0] term_r;
  item_t             s1_item_r;
  logic              s1_valid_r;
  logic [CODE_W-1:0] mem_q_r;
  logic              mem_ok_r;
  logic [CODE_W-1:0] s1_tbl;
  logic              s1_adv;

  logic [CODE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  mem_vld_r;

  dance_t            dance_r;
  dance_t            dance_nxt;
  rlist_t            results;

  res_t [2:0]        ob_r;
  logic [1:0]        ob_cnt_r;
  logic              out_beat;

  assign in_item.mode = mode_t'(in_tuser);
  assign in_item.row  = in_tdata[2:0];
  assign in_item.col  = in_tdata[5:3];
  assign in_item.down = in_tdata[6];
  assign in_item.code = in_tdata[22:7];
  assign in_item.now  = in_tdata[38:23];
  assign in_item.base = in_tdata[39];

  // keys of all rows but the last, corner key excluded
  assign in_edit = (in_item.row < 3'(ROWS - 1)) && ({1'b0, in_item.col} < 4'(COLS))
                 && !(in_item.row == 3'd0 && in_item.col == 3'd0);
  assign in_addr = in_edit ? AW'(int'(in_item.row) * COLS + int'(in_item.col)) : '0;

  assign in_beat = in_tvalid && in_tready;
  assign tbl_wr  = in_beat && in_item.mode == MODE_WRITE && in_edit;

  assign out_beat  = out_tvalid && out_tready;
  assign s1_adv    = s1_valid_r && (ob_cnt_r == 2'd0 || (ob_cnt_r == 2'd1 && out_tready));
  assign in_tready = !s1_valid_r || s1_adv;

  assign s1_tbl = mem_ok_r ? mem_q_r : '0;

  always_ff @(posedge clk) begin
    if (tbl_wr) mem[in_addr] <= in_item.code;
    if (in_beat) begin
      mem_q_r   <= mem[in_addr];
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r     <= TERM_RESET;
      mem_vld_r  <= '0;
      mem_ok_r   <= 1'b0;
      s1_valid_r <= 1'b0;
      dance_r    <= '0;
    end else begin
      if (cfg_wr_en) term_r <= cfg_wr_data;
      if (tbl_wr) mem_vld_r[in_addr] <= 1'b1;
      if (in_beat) mem_ok_r <= mem_vld_r[in_addr] && in_edit;
      if (in_beat) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) dance_r <= dance_nxt;
    end
  end

  pkdt_decide u_decide (
    .item      (s1_item_r),
    .dance     (dance_r),
    .term      (term_r),
    .tbl       (s1_tbl),
    .results   (results),
    .dance_nxt (dance_nxt)
  );

  // result buffer: load a whole list, shift one beat out per take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= 2'd0;
    end else if (s1_adv) begin
      ob_cnt_r <= results.cnt;
    end else if (out_beat) begin
      ob_cnt_r <= ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ob_r <= results.item;
    end else if (out_beat) begin
      ob_r[0] <= ob_r[1];
      ob_r[1] <= ob_r[2];
    end
  end

  assign out_tvalid = ob_cnt_r != 2'd0;
  assign out_tdata  = {7'd0, ob_r[0].consumed, ob_r[0].code};
  assign out_tuser  = ob_r[0].action;
  assign out_tlast  = ob_r[0].last;

endmodule

[hdl/pkdt_decide.sv]
// ----------------------------------------------------------------------------
// pkdt_decide
// Combinational decision for one item: result list and next dance state.
// ----------------------------------------------------------------------------
module pkdt_decide (
  input  pkdt_pkg::item_t             item,
  input  pkdt_pkg::dance_t            dance,
  input  logic [pkdt_pkg::TIME_W-1:0] term,
  input  logic [pkdt_pkg::CODE_W-1:0] tbl,
  output pkdt_pkg::rlist_t            results,
  output pkdt_pkg::dance_t            dance_nxt
);
  import pkdt_pkg::*;

  logic [TIME_W-1:0] elapsed;
  logic              timed_out;

  assign elapsed   = item.now - dance.start;
  assign timed_out = elapsed > term;

  always_comb begin
    dance_t st;
    rlist_t l;
    res_t   fin;
    logic   same;
    logic   done;

    st   = dance;
    l    = '0;
    same = (item.row == dance.row) && (item.col == dance.col);
    done = 1'b0;

    fin.action   = ACT_DONE;
    fin.code     = '0;
    fin.consumed = 1'b0;
    fin.last     = 1'b1;

    unique case (item.mode)
      MODE_KEY: begin
        // another key pressed first: resolve to the single code
        if (item.down && st.stage == ST_WAIT && !same) begin
          if (st.single != '0) l = push(l, key_res(ACT_REG, st.single));
          if (st.held) begin
            st.stage = ST_SINGLE;
          end else begin
            if (st.single != '0) l = push(l, key_res(ACT_UNREG, st.single));
            st = '0;
          end
        end

        if (!item.down) begin
          if (st.stage != ST_IDLE && same) begin
            fin.consumed = 1'b1;
            unique case (st.stage)
              ST_WAIT:   st.held = 1'b0;
              ST_SINGLE: begin
                if (st.single != '0) l = push(l, key_res(ACT_UNREG, st.single));
                st = '0;
              end
              default: begin
                if (st.dbl != '0) l = push(l, key_res(ACT_UNREG, st.dbl));
                st = '0;
              end
            endcase
          end
          done = 1'b1;
        end

        if (!done && st.stage == ST_WAIT && same) begin
          if (st.held) begin
            fin.consumed = 1'b1;
            done         = 1'b1;
          end else if (timed_out) begin
            // late second tap: tap the single code, then treat as fresh press
            if (st.single != '0) begin
              l = push(l, key_res(ACT_REG, st.single));
              l = push(l, key_res(ACT_UNREG, st.single));
            end
            st = '0;
          end else begin
            if (st.dbl != '0) l = push(l, key_res(ACT_REG, st.dbl));
            st.stage     = ST_DOUBLE;
            st.held      = 1'b1;
            fin.consumed = 1'b1;
            done         = 1'b1;
          end
        end

        // tbl is already zero for keys that are not editable
        if (!done && st.stage == ST_IDLE && item.base && tbl != '0) begin
          st.stage     = ST_WAIT;
          st.row       = item.row;
          st.col       = item.col;
          st.held      = 1'b1;
          st.start     = item.now;
          st.single    = item.code;
          st.dbl       = tbl;
          fin.consumed = 1'b1;
        end
      end
      MODE_POLL: begin
        if (st.stage == ST_WAIT && timed_out) begin
          if (st.single != '0) l = push(l, key_res(ACT_REG, st.single));
          if (st.held) begin
            st.stage = ST_SINGLE;
          end else begin
            if (st.single != '0) l = push(l, key_res(ACT_UNREG, st.single));
            st = '0;
          end
        end
      end
      MODE_WRITE: begin
      end
      MODE_READ: fin.code = tbl;
      default: begin
      end
    endcase

    l         = push(l, fin);
    results   = l;
    dance_nxt = st;
  end

endmodule

[hdl/pkdt_checker.sv]
// ----------------------------------------------------------------------------
// pkdt_checker
// Port-level checks on the result stream of the double-tap detector.
// ----------------------------------------------------------------------------
module pkdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import pkdt_pkg::*;

  // hold a stalled beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat shown straight after reset");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == ACT_DONE) == out_tlast))
    else $error("decision beat and tlast disagree");

  a_key_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ACT_DONE |->
      out_tdata[16] == 1'b0 && out_tdata[15:0] != 16'd0)
    else $error("register or unregister beat with zero code or consumed set");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:17] == 7'd0 && out_tuser != 2'd3)
    else $error("padding bits or action code out of range");

endmodule

bind per_key_double_tap_detector_unit pkdt_checker u_pkdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[bench/tb_per_key_double_tap_detector_unit.sv]
// ----------------------------------------------------------------------------
// tb_per_key_double_tap_detector_unit
// Self-checking bench for the per-key double-tap detector.
// ----------------------------------------------------------------------------
// A directed table covers table writes and reads (editable and not), polls,
// double taps, timeouts across the 16-bit wrap, interrupting keys, releases of
// other keys and zero keycodes. Random items on a few keys, mostly presses and
// releases, follow in four phases with different tapping terms and amounts of
// sender idling and receiver back-pressure. Every result beat is checked against
// the directed table or a behavioural model of the tap dance kept in the bench.
// ----------------------------------------------------------------------------
module tb_per_key_double_tap_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pkdt_pkg::*;

  localparam int ROWS = 6;
  localparam int COLS = 4;
  localparam int PHASE_ITEMS = 120;

  typedef struct {
    item_t       it;
    bit          typed;
    logic [15:0] code;
    bit          consumed;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  // model state
  logic [15:0] term_ms;
  stage_t      tap_stage;
  logic [2:0]  tap_row;
  logic [2:0]  tap_col;
  bit          tap_held;
  logic [15:0] tap_start;
  logic [15:0] tap_single;
  logic [15:0] tap_double;
  logic [15:0] dbl_codes [ROWS*COLS];

  res_t        new_beats [$];
  res_t        beats_due [$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // random stimulus state
  logic [15:0] ms_now = '0;
  bit          key_pressed [64];
  int          last_r = 0;
  int          last_c = 1;
  int          pool_r [4] = '{0, 1, 2, 4};
  int          pool_c [4] = '{1, 2, 3, 1};

  always #4 clk = ~clk;

  per_key_double_tap_detector_unit #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic item_t mk(mode_t m, int r, int c, bit d, int code, int now, bit b);
    item_t it;
    it.mode = m;
    it.row  = 3'(r);
    it.col  = 3'(c);
    it.down = d;
    it.code = 16'(code);
    it.now  = 16'(now);
    it.base = b;
    return it;
  endfunction

  function automatic res_t beat(act_t a, logic [15:0] code, bit cons, bit lst);
    res_t r;
    r.action   = a;
    r.code     = code;
    r.consumed = cons;
    r.last     = lst;
    return r;
  endfunction

  function automatic bit editable(logic [2:0] r, logic [2:0] c);
    return int'(r) < ROWS - 1 && int'(c) < COLS && !(r == 3'd0 && c == 3'd0);
  endfunction

  function automatic int slot(logic [2:0] r, logic [2:0] c);
    return int'(r) * COLS + int'(c);
  endfunction

  function automatic bit expired(logic [15:0] now);
    logic [15:0] el;
    el = now - tap_start;
    return el > term_ms;
  endfunction

  task automatic dance_clear();
    tap_stage  = ST_IDLE;
    tap_row    = '0;
    tap_col    = '0;
    tap_held   = 1'b0;
    tap_start  = '0;
    tap_single = '0;
    tap_double = '0;
  endtask

  // zero keycodes are never sent
  task automatic key_beat(act_t a, logic [15:0] code);
    if (code != 16'd0) new_beats.push_back(beat(a, code, 1'b0, 1'b0));
  endtask

  task automatic settle_single(bit hold);
    key_beat(ACT_REG, tap_single);
    if (hold) begin
      tap_stage = ST_SINGLE;
    end else begin
      key_beat(ACT_UNREG, tap_single);
      dance_clear();
    end
  endtask

  task automatic tap_decide(item_t it);
    bit          swallowed;
    bit          same;
    bit          settled;
    logic [15:0] rd;
    new_beats.delete();
    swallowed = 1'b0;
    settled   = 1'b0;
    rd        = '0;
    same      = it.row == tap_row && it.col == tap_col;
    case (it.mode)
      MODE_KEY: begin
        // another key pressed first: resolve the waiting dance to its single code
        if (it.down && tap_stage == ST_WAIT && !same) settle_single(tap_held);
        if (!it.down) begin
          if (tap_stage != ST_IDLE && same) begin
            case (tap_stage)
              ST_WAIT: tap_held = 1'b0;
              ST_SINGLE: begin
                key_beat(ACT_UNREG, tap_single);
                dance_clear();
              end
              default: begin
                key_beat(ACT_UNREG, tap_double);
                dance_clear();
              end
            endcase
            swallowed = 1'b1;
          end
        end else begin
          if (tap_stage == ST_WAIT && same) begin
            if (tap_held) begin
              swallowed = 1'b1;
              settled   = 1'b1;
            end else if (expired(it.now)) begin
              settle_single(1'b0);
            end else begin
              key_beat(ACT_REG, tap_double);
              tap_stage = ST_DOUBLE;
              tap_held  = 1'b1;
              swallowed = 1'b1;
              settled   = 1'b1;
            end
          end
          if (!settled && tap_stage == ST_IDLE && it.base && editable(it.row, it.col) &&
              dbl_codes[slot(it.row, it.col)] != 16'd0) begin
            tap_stage  = ST_WAIT;
            tap_row    = it.row;
            tap_col    = it.col;
            tap_held   = 1'b1;
            tap_start  = it.now;
            tap_single = it.code;
            tap_double = dbl_codes[slot(it.row, it.col)];
            swallowed  = 1'b1;
          end
        end
      end
      MODE_POLL: begin
        if (tap_stage == ST_WAIT && expired(it.now)) settle_single(tap_held);
      end
      MODE_WRITE: begin
        if (editable(it.row, it.col)) dbl_codes[slot(it.row, it.col)] = it.code;
      end
      default: begin
        if (editable(it.row, it.col)) rd = dbl_codes[slot(it.row, it.col)];
      end
    endcase
    new_beats.push_back(beat(ACT_DONE, rd, swallowed, 1'b1));
  endtask

  task automatic send_beat(item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= {it.base, it.now, it.code, it.down, it.col, it.row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // send one beat and book what it should produce
  task automatic issue(item_t it, bit typed, logic [15:0] code, bit cons);
    send_beat(it);
    tap_decide(it);
    if (typed) begin
      beats_due.push_back(beat(ACT_DONE, code, cons, 1'b1));
    end else begin
      foreach (new_beats[i]) beats_due.push_back(new_beats[i]);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_term(logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    term_ms = v;
  endtask

  function automatic item_t random_beat();
    item_t it;
    int    pick;
    int    k;
    int    step;
    int    r;
    int    c;
    bit    d;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: step = $urandom_range(20);
      5, 6, 7:       step = int'(term_ms) + int'($urandom_range(2)) - 1;
      default:       step = $urandom_range(65535);
    endcase
    ms_now = ms_now + 16'(step);
    k = $urandom_range(3);
    if ($urandom_range(1) == 1) begin
      r = last_r;
      c = last_c;
    end else if ($urandom_range(9) < 7) begin
      r = pool_r[k];
      c = pool_c[k];
    end else begin
      r = $urandom_range(7);
      c = $urandom_range(7);
    end
    if (pick < 70) begin
      // mostly alternate press and release per key so the dance gets deep
      d = ($urandom_range(99) < 85) ? !key_pressed[r*8+c] : 1'($urandom_range(1));
      key_pressed[r*8+c] = d;
      last_r = r;
      last_c = c;
      it = mk(MODE_KEY, r, c, d, ($urandom_range(9) == 0) ? 0 : $urandom_range(65535),
              ms_now, $urandom_range(9) != 0);
    end else if (pick < 85) begin
      it = mk(MODE_POLL, $urandom_range(7), $urandom_range(7), 1'($urandom_range(1)),
              $urandom_range(65535), ms_now, 1'($urandom_range(1)));
    end else begin
      it = mk((pick < 93) ? MODE_WRITE : MODE_READ, r, c, 1'($urandom_range(1)),
              ($urandom_range(4) == 0) ? 0 : $urandom_range(65535), ms_now,
              1'($urandom_range(1)));
    end
    return it;
  endfunction

  task automatic report(string why, res_t want, res_t got);
    errors++;
    if (errors <= 10)
      $display("%s: expected act=%0d code=%h cons=%b last=%b, got act=%0d code=%h cons=%b last=%b",
               why, want.action, want.code, want.consumed, want.last,
               got.action, got.code, got.consumed, got.last);
  endtask

  always @(posedge clk) begin : watch_out
    res_t got;
    res_t want;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got = beat(act_t'(out_tuser), out_tdata[15:0], out_tdata[16], out_tlast);
      if (beats_due.size() == 0) begin
        report("beat with nothing expected", '0, got);
      end else begin
        want = beats_due.pop_front();
        if (got !== want) report("beat mismatch", want, got);
      end
    end
  end

  initial begin : run
    dir_row_t    dir_tab [$];
    logic [15:0] ph_term [4];
    int          ph_send [4];
    int          ph_recv [4];

    term_ms = TERM_RESET;
    dance_clear();
    foreach (dbl_codes[i]) dbl_codes[i] = '0;
    ph_term = '{16'hFFFF, 16'd0, 16'd150, 16'($urandom_range(20, 600))};
    ph_send = '{0, 61, 0, 30};
    ph_recv = '{0, 0, 61, 30};

    // table after reset, positions outside the editable area, polls while idle
    dir_tab.push_back(dir_row_t'{mk(MODE_READ, 0, 1, 0, 0, 0, 1), 1, 16'h0000, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_READ, 7, 7, 1, 'hFFFF, 'hFFFF, 1), 1, 16'h0000, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_WRITE, 5, 0, 0, 'hFFFF, 0, 1), 1, 16'h0000, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_READ, 5, 0, 0, 0, 0, 1), 1, 16'h0000, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_WRITE, 0, 0, 0, 'h1234, 0, 1), 1, 16'h0000, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_WRITE, 1, 2, 0, 'hFFFF, 0, 1), 1, 16'h0000, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_READ, 1, 2, 0, 0, 0, 1), 1, 16'hFFFF, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_WRITE, 0, 1, 0, 'h0005, 0, 1), 1, 16'h0000, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_POLL, 0, 0, 0, 0, 0, 0), 1, 16'h0000, 0});
    // double tap, second press while still held
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 0, 1, 1, 'h0004, 100, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 0, 1, 1, 'h0004, 120, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 0, 1, 0, 'h0004, 130, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 0, 1, 1, 'h0004, 150, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 0, 1, 0, 'h0004, 160, 1), 0, '0, 0});
    // zero single code timing out across the wrap
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 0, 1, 1, 0, 'hFFF0, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 0, 1, 0, 0, 'hFFF8, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_POLL, 0, 1, 0, 0, 'h00D0, 1), 0, '0, 0});
    // off the base layer, then an interrupting key and a stray release
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 0, 1, 1, 'hFFFF, 1000, 0), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 0, 1, 1, 'h0020, 1000, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 1, 2, 1, 'h0007, 1010, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 3, 3, 0, 'h0007, 1020, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 0, 1, 0, 'h0020, 1030, 1), 0, '0, 0});
    // late second press restarts the dance, then a poll resolves a held key
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 1, 2, 1, 'h0009, 2000, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 1, 2, 0, 'h0009, 2050, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 1, 2, 1, 'h0009, 2201, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_POLL, 1, 2, 0, 0, 2601, 1), 0, '0, 0});
    dir_tab.push_back(dir_row_t'{mk(MODE_KEY, 1, 2, 0, 'h0009, 2700, 1), 0, '0, 0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) issue(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].code,
                               dir_tab[i].consumed);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      set_term(ph_term[ph]);
      send_idle_pct  = ph_send[ph];
      recv_stall_pct = ph_recv[ph];
      repeat (PHASE_ITEMS) issue(random_beat(), 1'b0, '0, 1'b0);
    end

    drain();
    repeat (10) @(posedge clk);
    if (beats_due.size() != 0) begin
      errors += beats_due.size();
      $display("%0d expected beats never arrived", beats_due.size());
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // about 510 items, at most three beats each, with long stalls: the run ends well before the watchdog fires
  initial begin : watchdog
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
